// ===== rtl/chsf_pkg.sv =====
// ----------------------------------------------------------------------------
// chsf_pkg
// Shared constants and types of the cascaded Holt shelf filter.
// ----------------------------------------------------------------------------
package chsf_pkg;

  // Fixed-point layout
  localparam int GUARD_BITS = 4;   // state = sample << GUARD_BITS
  localparam int GAIN_FRAC  = 14;  // wet gain is Q2.14 signed, dry gain Q1.14 unsigned
  localparam int MAX_SHIFT  = 16;  // larger shift codes act as zero

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FREQ_SHIFT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WET_GAIN    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRY_GAIN    = 2'd3;

  // Register widths and reset values
  localparam int FREQ_W  = 5;
  localparam int STAGE_W = 4;
  localparam int WET_W   = 16;
  localparam int DRY_W   = 15;

  localparam logic [FREQ_W-1:0]         FREQ_RST  = 5'd10;
  localparam logic [STAGE_W-1:0]        STAGE_RST = 4'd5;
  localparam logic signed [WET_W-1:0]   WET_RST   = 16'sd16384;
  localparam logic [DRY_W-1:0]          DRY_RST   = 15'd0;

  // Phase strobes from the sequencer to the pole unit
  typedef struct packed {
    logic sum_en;  // capture level + slew
    logic err_en;  // capture input - (level + slew)
  } pole_ctl_t;

endpackage

// ===== rtl/cascaded_holt_shelf_filter.sv =====
// ----------------------------------------------------------------------------
// cascaded_holt_shelf_filter
// Stereo cascade of Holt poles with 2^-shift coefficient and wet/dry mix.
// ----------------------------------------------------------------------------
// One beat carries a left and right sample. Each channel runs through
// stage_count poles (capped at MAX_STAGES), left first, then right, on one
// shared pole unit that steps each pole through sum, error and update. The
// mix uses one shared multiplier: filtered * wet, then + dry * input, then a
// round/saturate step, for each channel. After the input beat is taken the
// block is busy until both channels are mixed; in_ready_o is high only while
// idle. The result sits in an output register, so a new input beat is taken
// while the previous result still waits; the next result then holds in the
// right channel's round step until the output register frees up. The user
// writes registers through cfg_we_i / cfg_idx_i / cfg_wdata_i only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module cascaded_holt_shelf_filter #(
  parameter int MAX_STAGES  = 10,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [chsf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [chsf_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // input beats
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]      left_in_i,
  input  logic signed [SAMPLE_BITS-1:0]      right_in_i,
  // result beats
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]      left_out_o,
  output logic signed [SAMPLE_BITS-1:0]      right_out_o
);

  localparam int STATE_BITS = SAMPLE_BITS + chsf_pkg::GUARD_BITS;
  localparam int NUM_POLES  = 2 * MAX_STAGES;
  localparam int IDX_W      = $clog2(NUM_POLES);
  localparam int KW         = $clog2(MAX_STAGES + 1);
  localparam int MUL_B_W    = chsf_pkg::WET_W + 1;
  localparam int ACC_W      = STATE_BITS + MUL_B_W;
  localparam int RND_SH     = chsf_pkg::GAIN_FRAC + chsf_pkg::GUARD_BITS;

  // sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SUM  = 3'd1;
  localparam logic [2:0] ST_ERR  = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_MWET = 3'd4;
  localparam logic [2:0] ST_MDRY = 3'd5;
  localparam logic [2:0] ST_RND  = 3'd6;

  // config registers
  logic [chsf_pkg::FREQ_W-1:0]        freq_shift_q;
  logic [chsf_pkg::STAGE_W-1:0]       stage_count_q;
  logic signed [chsf_pkg::WET_W-1:0]  wet_gain_q;
  logic [chsf_pkg::DRY_W-1:0]         dry_gain_q;

  // sequencer
  logic [2:0]     state_q;
  logic           ch_q;       // 0 = left, 1 = right
  logic [KW-1:0]  k_q;        // current pole
  logic           out_valid_q;

  // pole state, entry {stage, channel}
  logic signed [STATE_BITS-1:0] lvl_q [NUM_POLES];
  logic signed [STATE_BITS-1:0] slw_q [NUM_POLES];

  // payload
  logic signed [SAMPLE_BITS-1:0] xl_q, xr_q;
  logic signed [STATE_BITS-1:0]  x_q;       // running stage input / filtered value
  logic signed [ACC_W-1:0]       acc_q;
  logic signed [SAMPLE_BITS-1:0] res_l_q;
  logic signed [SAMPLE_BITS-1:0] left_out_q, right_out_q;

  // effective settings
  logic [chsf_pkg::FREQ_W-1:0] shift_eff;
  logic [KW-1:0]               stages_eff;
  logic                        no_stages;
  logic                        last_pole;
  logic [IDX_W-1:0]            idx;

  // pole unit hookup
  chsf_pkg::pole_ctl_t          pole_ctl;
  logic signed [STATE_BITS-1:0] new_lvl, new_slw;

  // mix datapath
  logic signed [SAMPLE_BITS-1:0] xin;
  logic signed [STATE_BITS-1:0]  xin_ext;
  logic signed [STATE_BITS-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]     mul_b;
  logic signed [ACC_W-1:0]       prod;
  logic signed [ACC_W-1:0]       rnd_sum, rnd_sh;
  logic signed [SAMPLE_BITS-1:0] rnd_out;
  logic [ACC_W-SAMPLE_BITS:0]    rnd_top;
  logic                          out_free;
  logic                          out_load;

  // shift codes past sixteen mean coefficient one
  assign shift_eff = (freq_shift_q > chsf_pkg::FREQ_W'(chsf_pkg::MAX_SHIFT)) ?
                     '0 : freq_shift_q;

  always_comb begin
    if (32'(stage_count_q) > MAX_STAGES) begin
      stages_eff = KW'(MAX_STAGES);
    end else begin
      stages_eff = KW'(stage_count_q);
    end
  end

  assign no_stages = (stages_eff == '0);
  assign last_pole = (KW'(k_q + 1'b1) == stages_eff);
  assign idx       = IDX_W'({k_q, ch_q});

  assign pole_ctl.sum_en = (state_q == ST_SUM);
  assign pole_ctl.err_en = (state_q == ST_ERR);

  chsf_pole_unit #(
    .STATE_BITS (STATE_BITS)
  ) u_pole (
    .clk_i   (clk_i),
    .ctl_i   (pole_ctl),
    .x_i     (x_q),
    .lvl_i   (lvl_q[idx]),
    .slw_i   (slw_q[idx]),
    .shift_i (shift_eff),
    .lvl_o   (new_lvl),
    .slw_o   (new_slw)
  );

  // shared multiplier: filtered * wet, then dry input * dry
  assign xin     = ch_q ? xr_q : xl_q;
  assign xin_ext = {xin, {chsf_pkg::GUARD_BITS{1'b0}}};
  assign mul_a   = (state_q == ST_MWET) ? x_q : xin_ext;
  assign mul_b   = (state_q == ST_MWET) ? {wet_gain_q[chsf_pkg::WET_W-1], wet_gain_q}
                                        : {2'b00, dry_gain_q};
  assign prod    = mul_a * mul_b;

  // round half up, drop gain and guard fraction, saturate to the sample width
  assign rnd_sum = acc_q + (ACC_W'(1) <<< (RND_SH - 1));
  assign rnd_sh  = rnd_sum >>> RND_SH;
  assign rnd_top = rnd_sh[ACC_W-1:SAMPLE_BITS-1];

  always_comb begin
    if ((&rnd_top) || !(|rnd_top)) begin
      rnd_out = rnd_sh[SAMPLE_BITS-1:0];
    end else if (rnd_sh[ACC_W-1]) begin
      rnd_out = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      rnd_out = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  // right channel finished and the output register can take the pair
  assign out_load = (state_q == ST_RND) && ch_q && out_free;

  // control, config and pole state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_shift_q  <= chsf_pkg::FREQ_RST;
      stage_count_q <= chsf_pkg::STAGE_RST;
      wet_gain_q    <= chsf_pkg::WET_RST;
      dry_gain_q    <= chsf_pkg::DRY_RST;
      state_q       <= ST_IDLE;
      ch_q          <= 1'b0;
      k_q           <= '0;
      out_valid_q   <= 1'b0;
      for (int i = 0; i < NUM_POLES; i++) begin
        lvl_q[i] <= '0;
        slw_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          chsf_pkg::REG_FREQ_SHIFT:  freq_shift_q  <= cfg_wdata_i[chsf_pkg::FREQ_W-1:0];
          chsf_pkg::REG_STAGE_COUNT: stage_count_q <= cfg_wdata_i[chsf_pkg::STAGE_W-1:0];
          chsf_pkg::REG_WET_GAIN:    wet_gain_q    <= cfg_wdata_i[chsf_pkg::WET_W-1:0];
          chsf_pkg::REG_DRY_GAIN:    dry_gain_q    <= cfg_wdata_i[chsf_pkg::DRY_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            ch_q    <= 1'b0;
            k_q     <= '0;
            state_q <= no_stages ? ST_MWET : ST_SUM;
          end
        end
        ST_SUM:  state_q <= ST_ERR;
        ST_ERR:  state_q <= ST_UPD;
        ST_UPD: begin
          lvl_q[idx] <= new_lvl;
          slw_q[idx] <= new_slw;
          k_q        <= KW'(k_q + 1'b1);
          state_q    <= last_pole ? ST_MWET : ST_SUM;
        end
        ST_MWET: state_q <= ST_MDRY;
        ST_MDRY: state_q <= ST_RND;
        ST_RND: begin
          if (!ch_q) begin
            ch_q    <= 1'b1;
            k_q     <= '0;
            state_q <= no_stages ? ST_MWET : ST_SUM;
          end else if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload path
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          xl_q <= left_in_i;
          xr_q <= right_in_i;
          x_q  <= {left_in_i, {chsf_pkg::GUARD_BITS{1'b0}}};
        end
      end
      ST_UPD:  x_q   <= new_lvl;
      ST_MWET: acc_q <= prod;
      ST_MDRY: acc_q <= acc_q + prod;
      ST_RND: begin
        if (!ch_q) begin
          res_l_q <= rnd_out;
          x_q     <= {xr_q, {chsf_pkg::GUARD_BITS{1'b0}}};
        end else if (out_free) begin
          left_out_q  <= res_l_q;
          right_out_q <= rnd_out;
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_out_q;
  assign right_out_o = right_out_q;

endmodule

// ===== rtl/chsf_pole_unit.sv =====
// ----------------------------------------------------------------------------
// chsf_pole_unit
// Shared Holt pole datapath: three phases per pole update.
// ----------------------------------------------------------------------------
module chsf_pole_unit #(
  parameter int STATE_BITS = 28
) (
  input  logic                                clk_i,
  input  chsf_pkg::pole_ctl_t                 ctl_i,
  input  logic signed [STATE_BITS-1:0]        x_i,
  input  logic signed [STATE_BITS-1:0]        lvl_i,
  input  logic signed [STATE_BITS-1:0]        slw_i,
  input  logic [chsf_pkg::FREQ_W-1:0]         shift_i,
  output logic signed [STATE_BITS-1:0]        lvl_o,
  output logic signed [STATE_BITS-1:0]        slw_o
);

  // three headroom bits cover x - L - S + 2S and friends
  localparam int W = STATE_BITS + 3;

  logic signed [W-1:0] sum_q;
  logic signed [W-1:0] err_q;
  logic signed [W-1:0] x_ext, lvl_ext, slw_ext;
  logic signed [W-1:0] slw_sum, slw_raw, lvl_raw;
  logic [chsf_pkg::FREQ_W-1:0] shift_p1;

  function automatic logic signed [STATE_BITS-1:0] sat_state(input logic signed [W-1:0] v);
    logic [W-STATE_BITS:0] top;
    begin
      top = v[W-1:STATE_BITS-1];
      if ((&top) || !(|top)) begin
        sat_state = v[STATE_BITS-1:0];
      end else if (v[W-1]) begin
        sat_state = {1'b1, {(STATE_BITS-1){1'b0}}};
      end else begin
        sat_state = {1'b0, {(STATE_BITS-1){1'b1}}};
      end
    end
  endfunction

  assign x_ext   = {{3{x_i[STATE_BITS-1]}}, x_i};
  assign lvl_ext = {{3{lvl_i[STATE_BITS-1]}}, lvl_i};
  assign slw_ext = {{3{slw_i[STATE_BITS-1]}}, slw_i};

  // phase 1: L + S ; phase 2: x - (L + S)
  always_ff @(posedge clk_i) begin
    if (ctl_i.sum_en) begin
      sum_q <= lvl_ext + slw_ext;
    end
    if (ctl_i.err_en) begin
      err_q <= x_ext - sum_q;
    end
  end

  // phase 3: x - L + S = err + 2S, both results in parallel
  assign shift_p1 = shift_i + 5'd1;
  assign slw_sum  = err_q + (slw_ext <<< 1);
  assign slw_raw  = slw_sum >>> shift_p1;
  assign lvl_raw  = sum_q + (err_q >>> shift_i);

  assign slw_o = sat_state(slw_raw);
  assign lvl_o = sat_state(lvl_raw);

endmodule

// ===== rtl/chsf_checker.sv =====
// ----------------------------------------------------------------------------
// chsf_checker
// Port-level checks of the cascaded Holt shelf filter, bound to the top.
// ----------------------------------------------------------------------------
module chsf_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic signed [SAMPLE_BITS-1:0] left_out_o,
  input logic signed [SAMPLE_BITS-1:0] right_out_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(left_out_o)
                                    && $stable(right_out_o))
    else $error("result beat changed while stalled");

  // one beat at a time: busy right after an input beat
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a beat is in flight");

  // a new result only comes out of the busy phase
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without work in flight");

  // the mix alone runs the wet, dry and round states, so no result right after input
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result too soon after input beat");

endmodule

bind cascaded_holt_shelf_filter chsf_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_chsf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .left_out_o  (left_out_o),
  .right_out_o (right_out_o)
);

// ===== verif/holt_shelf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// holt_shelf_checker
// Watches the config port and both beat channels of the Holt shelf filter,
// predicts every mixed stereo result and compares it with the result beats.
// ----------------------------------------------------------------------------
module holt_shelf_checker
  import chsf_pkg::*;
#(
  parameter int MAX_STAGES  = 10,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic signed [SAMPLE_BITS-1:0] left_in_i,
  input  logic signed [SAMPLE_BITS-1:0] right_in_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic signed [SAMPLE_BITS-1:0] left_out_i,
  input  logic signed [SAMPLE_BITS-1:0] right_out_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);

  localparam int STATE_BITS = SAMPLE_BITS + GUARD_BITS;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
  } stereo_t;

  logic [FREQ_W-1:0]        shift_q;
  logic [STAGE_W-1:0]       stages_q;
  logic signed [WET_W-1:0]  wet_q;
  logic [DRY_W-1:0]         dry_q;

  // pole state, entry 2*stage + channel (left = 0)
  longint level_q [2*MAX_STAGES];
  longint slew_q  [2*MAX_STAGES];

  stereo_t expected_mix_q [$];

  function automatic longint clamp(longint v, int w);
    longint lim;
    lim = longint'(1) << (w - 1);
    if (v < -lim) return -lim;
    if (v > lim - 1) return lim - 1;
    return v;
  endfunction

  // Steps the active poles of one channel; returns the last level (the input when none is active).
  function automatic longint run_poles(longint x, int ch);
    int     n;
    int     s;
    int     idx;
    longint lv;
    longint sl;
    longint sum;
    n = (stages_q > MAX_STAGES) ? MAX_STAGES : int'(stages_q);
    s = (shift_q > MAX_SHIFT) ? 0 : int'(shift_q);
    for (int k = 0; k < n; k++) begin
      idx = 2 * k + ch;
      lv  = level_q[idx];
      sl  = slew_q[idx];
      sum = lv + sl;
      slew_q[idx]  = clamp((x - lv + sl) >>> (s + 1), STATE_BITS);
      level_q[idx] = clamp(sum + ((x - sum) >>> s), STATE_BITS);
      x = level_q[idx];
    end
    return x;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] mix_sample(longint dry_x, longint wet_y);
    longint acc;
    acc = wet_y * longint'(wet_q) + dry_x * longint'(dry_q);
    acc = (acc + (longint'(1) << (GAIN_FRAC + GUARD_BITS - 1))) >>> (GAIN_FRAC + GUARD_BITS);
    return SAMPLE_BITS'(clamp(acc, SAMPLE_BITS));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    stereo_t want;
    longint  xl;
    longint  xr;
    if (!rst_ni) begin
      shift_q  = FREQ_RST;
      stages_q = STAGE_RST;
      wet_q    = WET_RST;
      dry_q    = DRY_RST;
      foreach (level_q[i]) begin
        level_q[i] = 0;
        slew_q[i]  = 0;
      end
      expected_mix_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_mix_q.size() == 0) begin
          $error("result beat with nothing pending: left_out %0d right_out %0d",
                 left_out_i, right_out_i);
          fail_count_o++;
        end else begin
          want = expected_mix_q.pop_front();
          if (left_out_i !== want.left) begin
            $error("left_out mismatch: expected %0d, got %0d", want.left, left_out_i);
            fail_count_o++;
          end
          if (right_out_i !== want.right) begin
            $error("right_out mismatch: expected %0d, got %0d", want.right, right_out_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        xl = longint'(left_in_i) * (longint'(1) << GUARD_BITS);
        xr = longint'(right_in_i) * (longint'(1) << GUARD_BITS);
        want.left  = mix_sample(xl, run_poles(xl, 0));
        want.right = mix_sample(xr, run_poles(xr, 1));
        expected_mix_q.push_back(want);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FREQ_SHIFT:  shift_q  = cfg_wdata_i[FREQ_W-1:0];
          REG_STAGE_COUNT: stages_q = cfg_wdata_i[STAGE_W-1:0];
          REG_WET_GAIN:    wet_q    = cfg_wdata_i[WET_W-1:0];
          REG_DRY_GAIN:    dry_q    = cfg_wdata_i[DRY_W-1:0];
          default: ;
        endcase
      end
      pending_o = expected_mix_q.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives stereo sample beats and register settings into the cascaded Holt
// shelf filter; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;
  import chsf_pkg::*;

  localparam int MAX_STAGES     = 10;
  localparam int SAMPLE_BITS    = 24;
  localparam int CLK_HALF       = 2;     // 4 ns period
  localparam int RESET_CYCLES   = 9;
  localparam int RAND_PHASES    = 10;
  localparam int PHASE_ITEMS    = 50;    // 500 random beats in all
  localparam int CALM_PHASE     = 4;     // no idling on either side here
  localparam int IDLE_PCT       = 13;
  localparam int DRAIN_CYCLES   = 80;    // wait after the last result before the final check
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any beat

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // shapes of the random sample runs
  typedef enum int unsigned {
    WAVE_NOISE,
    WAVE_STEP,
    WAVE_RAMP,
    WAVE_SQUARE
  } wave_e;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [CFG_IDX_W-1:0]          cfg_idx_i;
  logic [CFG_DATA_W-1:0]         cfg_wdata_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic signed [SAMPLE_BITS-1:0] left_in_i;
  logic signed [SAMPLE_BITS-1:0] right_in_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic signed [SAMPLE_BITS-1:0] left_out_o;
  logic signed [SAMPLE_BITS-1:0] right_out_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles;
  logic        calm;   // suppresses random idling on both sides

  always #(CLK_HALF) clk_i = ~clk_i;

  cascaded_holt_shelf_filter #(
    .MAX_STAGES  (MAX_STAGES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) dut (.*);

  holt_shelf_checker #(
    .MAX_STAGES  (MAX_STAGES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .left_in_i    (left_in_i),
    .right_in_i   (right_in_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .left_out_i   (left_out_o),
    .right_out_i  (right_out_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Result side: back-pressure in about one cycle of eight, never while calm.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i = calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: any beat on either channel restarts the count.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // One sample beat. Valid goes up at a falling edge (after an optional
  // idle gap) and stays up until a rising edge sees ready; the next call
  // decides at the following falling edge whether it drops.
  task automatic send_pair(input logic signed [SAMPLE_BITS-1:0] l,
                           input logic signed [SAMPLE_BITS-1:0] r);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    left_in_i  = l;
    right_in_i = r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
  endtask

  // Drain every pending result, then rewrite all four registers.
  // Every beat yields a result, so once the last one is out the block is
  // idle; the task still pauses before the first write.
  task automatic retune(input logic [CFG_DATA_W-1:0] shift_w, input logic [CFG_DATA_W-1:0] stage_w,
                        input logic [CFG_DATA_W-1:0] wet_w, input logic [CFG_DATA_W-1:0] dry_w);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk_i);
    put_reg(REG_FREQ_SHIFT, shift_w);
    put_reg(REG_STAGE_COUNT, stage_w);
    put_reg(REG_WET_GAIN, wet_w);
    put_reg(REG_DRY_GAIN, dry_w);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  initial begin
    logic signed [SAMPLE_BITS-1:0] base_l, base_r, step_l, step_r, pl, pr;
    logic [CFG_DATA_W-1:0]         shift_w, stage_w, wet_w, dry_w;
    wave_e                         wave;
    int unsigned                   run_len;
    int unsigned                   sent;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_FREQ_SHIFT;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    left_in_i   = '0;
    right_in_i  = '0;
    calm        = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // --- directed ---
    // reset settings: shift 10, five poles, unity wet, no dry
    send_pair(S_MAX, S_MIN);
    send_pair(S_MAX, S_MIN);
    send_pair('0, -24'sd1);
    send_pair(S_MIN, S_MAX);

    // coefficient one, all ten poles, inverted wet, full dry: hard
    // full-scale steps push the level/slew state into saturation
    retune(16'd0, 16'd10, -16'sd16384, 16'd16384);
    send_pair(S_MAX, S_MAX);
    send_pair(S_MIN, S_MIN);
    send_pair(S_MAX, S_MIN);
    send_pair(S_MIN, S_MAX);

    // no poles: filtered path is the dry input, so wet + dry doubles it
    retune(16'd16, 16'd0, 16'sd16384, 16'd16384);
    send_pair(S_MAX, S_MIN);
    send_pair(24'sd1, -24'sd1);
    send_pair(S_MIN, S_MAX);

    // all-ones words but for wet: shift 31 acts as zero, stage code 15 caps at ten,
    // wet -32768 and dry 32767 are taken at full register width
    retune(16'hFFFF, 16'hFFFF, 16'h8000, 16'hFFFF);
    send_pair(S_MAX, S_MIN);
    send_pair(S_MIN, S_MAX);
    send_pair(S_MAX, S_MAX);
    send_pair('0, '0);

    // three poles, then one (poles two and three must hold), then six
    retune(16'd1, 16'd3, 16'sd32767, 16'd0);
    send_pair(S_MAX, S_MIN);
    send_pair(S_MAX, S_MIN);
    retune(16'd1, 16'd1, 16'sd32767, 16'd0);
    send_pair(S_MIN, S_MAX);
    send_pair('0, '0);
    retune(16'd1, 16'd6, 16'sd32767, 16'd0);
    send_pair(S_MAX, S_MAX);
    send_pair('0, '0);

    // --- random ---
    // Each phase picks new settings (junk in the unused upper bits), then
    // runs of noise, held steps, ramps and full-scale squares.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      shift_w = CFG_DATA_W'($urandom());
      shift_w[FREQ_W-1:0] = FREQ_W'(($urandom_range(99) < 12) ? $urandom_range(31, MAX_SHIFT + 1)
                                                              : $urandom_range(MAX_SHIFT));
      stage_w = CFG_DATA_W'($urandom());
      stage_w[STAGE_W-1:0] = STAGE_W'(($urandom_range(99) < 10) ?
                                      $urandom_range(15, MAX_STAGES + 1) :
                                      $urandom_range(MAX_STAGES));
      wet_w = CFG_DATA_W'(($urandom_range(99) < 15) ? $urandom()
                                                    : (int'($urandom_range(32768)) - 16384));
      dry_w = CFG_DATA_W'(($urandom_range(99) < 15) ? $urandom() : $urandom_range(16384));
      retune(shift_w, stage_w, wet_w, dry_w);
      calm = (ph == CALM_PHASE);

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        wave    = wave_e'($urandom_range(3));
        run_len = $urandom_range(24, 4);
        base_l  = SAMPLE_BITS'($urandom());
        base_r  = SAMPLE_BITS'($urandom());
        step_l  = SAMPLE_BITS'($urandom());
        step_r  = SAMPLE_BITS'($urandom());
        step_l  = step_l >>> $urandom_range(20, 6);
        step_r  = step_r >>> $urandom_range(20, 6);
        for (int k = 0; k < run_len && sent < PHASE_ITEMS; k++) begin
          case (wave)
            WAVE_NOISE: begin
              pl = SAMPLE_BITS'($urandom());
              pr = SAMPLE_BITS'($urandom());
            end
            WAVE_STEP: begin
              pl = base_l;
              pr = base_r;
            end
            WAVE_RAMP: begin
              pl = SAMPLE_BITS'(base_l + step_l * k);   // wraps, which makes big jumps too
              pr = SAMPLE_BITS'(base_r + step_r * k);
            end
            default: begin
              pl = k[1] ? S_MAX : S_MIN;
              pr = k[1] ? S_MIN : S_MAX;
            end
          endcase
          send_pair(pl, pr);
          sent++;
        end
      end
    end

    // --- wrap up ---
    @(negedge clk_i);
    in_valid_i = 1'b0;
    calm = 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/chsf_pkg.sv
rtl/chsf_pole_unit.sv
rtl/cascaded_holt_shelf_filter.sv
rtl/chsf_checker.sv
verif/holt_shelf_checker.sv
verif/tb_top.sv
